/* src/spct_pkg.sv */
// types and constants for the sphere pair contact test
// no dependencies; imported by the top level and its checker
package spct_pkg;

  localparam int CoordW   = 32;
  localparam int NormFrac = 14;
  localparam int NormW    = NormFrac + 2;
  localparam int MagW     = CoordW + 1;
  localparam int SqW      = 2 * MagW;
  localparam int SumW     = SqW + 2;
  localparam int RootW    = SumW / 2;
  localparam int RemW     = RootW + 2;
  localparam int QW       = NormFrac + 2;
  localparam int DivW     = RootW + NormFrac + 3;
  localparam int Latency  = 4 + RootW + QW;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic [CoordW-2:0]        radius_a;
    logic [CoordW-2:0]        radius_b;
    logic                     same_body;
    logic signed [CoordW-1:0] rest_dx;
    logic signed [CoordW-1:0] rest_dy;
    logic signed [CoordW-1:0] rest_dz;
  } in_t;

  typedef struct packed {
    logic                     in_contact;
    logic signed [CoordW-1:0] mid_x;
    logic signed [CoordW-1:0] mid_y;
    logic signed [CoordW-1:0] mid_z;
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
  } out_t;

  // what travels with an item through the sqrt and divide stages
  typedef struct packed {
    logic                       hit;
    logic                       d2nz;
    logic [2:0][CoordW-1:0]     mid;
    logic [2:0][MagW-1:0]       mag;
    logic [2:0]                 neg;
  } carry_t;

endpackage

/* src/sphere_pair_contact_test.sv */
// sphere pair contact test: one item per cycle
// pipelined square root (one root bit per stage, 34 stages) feeds the
// pipelined normal divide (one quotient bit per stage, 16 stages)
// throughput one item per clock; busy is always low and results cannot be stalled
// reset clears all valid bits; items in flight are dropped
// depends on spct_pkg
module sphere_pair_contact_test (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spct_pkg::in_t in_i,
  output logic          valid_o,
  output spct_pkg::out_t result_o
);
  import spct_pkg::*;

  // stage 1: differences, magnitudes, midpoints, radius sum
  logic [CoordW-1:0] ax [3];
  logic [CoordW-1:0] bx [3];
  logic [CoordW-1:0] rx [3];
  logic [MagW-1:0]   dv [3];
  logic [MagW-1:0]   sv [3];
  logic [MagW-1:0]   rv [3];

  assign ax[0] = in_i.a_x;
  assign ax[1] = in_i.a_y;
  assign ax[2] = in_i.a_z;
  assign bx[0] = in_i.b_x;
  assign bx[1] = in_i.b_y;
  assign bx[2] = in_i.b_z;
  assign rx[0] = in_i.rest_dx;
  assign rx[1] = in_i.rest_dy;
  assign rx[2] = in_i.rest_dz;

  logic                   s1_valid_q;
  logic [2:0][MagW-1:0]   s1_mag_q, s1_rmag_q;
  logic [2:0]             s1_neg_q;
  logic [2:0][CoordW-1:0] s1_mid_q;
  logic [CoordW-1:0]      s1_rs_q;
  logic                   s1_same_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dv[a] = {bx[a][CoordW-1], bx[a]} - {ax[a][CoordW-1], ax[a]};
      sv[a] = {bx[a][CoordW-1], bx[a]} + {ax[a][CoordW-1], ax[a]};
      rv[a] = {rx[a][CoordW-1], rx[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      s1_mag_q[a]  <= dv[a][MagW-1] ? (~dv[a] + 1'b1) : dv[a];
      s1_rmag_q[a] <= rv[a][MagW-1] ? (~rv[a] + 1'b1) : rv[a];
      s1_neg_q[a]  <= dv[a][MagW-1];
      s1_mid_q[a]  <= sv[a][MagW-1:1];
    end
    s1_rs_q   <= CoordW'(in_i.radius_a) + CoordW'(in_i.radius_b);
    s1_same_q <= in_i.same_body;
  end

  // stage 2: squares
  logic                   s2_valid_q;
  logic [2:0][SqW-1:0]    s2_sq_q, s2_rsq_q;
  logic [2*CoordW-1:0]    s2_r2_q;
  logic [2:0][MagW-1:0]   s2_mag_q;
  logic [2:0]             s2_neg_q;
  logic [2:0][CoordW-1:0] s2_mid_q;
  logic                   s2_same_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      s2_sq_q[a]  <= SqW'(s1_mag_q[a]) * SqW'(s1_mag_q[a]);
      s2_rsq_q[a] <= SqW'(s1_rmag_q[a]) * SqW'(s1_rmag_q[a]);
    end
    s2_r2_q   <= (2*CoordW)'(s1_rs_q) * (2*CoordW)'(s1_rs_q);
    s2_mag_q  <= s1_mag_q;
    s2_neg_q  <= s1_neg_q;
    s2_mid_q  <= s1_mid_q;
    s2_same_q <= s1_same_q;
  end

  // stage 3: sums of squares
  logic                   s3_valid_q;
  logic [SumW-1:0]        s3_d2_q, s3_rest2_q;
  logic [2*CoordW-1:0]    s3_r2_q;
  logic [2:0][MagW-1:0]   s3_mag_q;
  logic [2:0]             s3_neg_q;
  logic [2:0][CoordW-1:0] s3_mid_q;
  logic                   s3_same_q;

  always_ff @(posedge clk_i) begin
    s3_d2_q    <= SumW'(s2_sq_q[0]) + SumW'(s2_sq_q[1]) + SumW'(s2_sq_q[2]);
    s3_rest2_q <= SumW'(s2_rsq_q[0]) + SumW'(s2_rsq_q[1]) + SumW'(s2_rsq_q[2]);
    s3_r2_q    <= s2_r2_q;
    s3_mag_q   <= s2_mag_q;
    s3_neg_q   <= s2_neg_q;
    s3_mid_q   <= s2_mid_q;
    s3_same_q  <= s2_same_q;
  end

  // stage 4: contact decision
  logic            s4_valid_q;
  logic [SumW-1:0] s4_d2_q;
  carry_t          s4_carry_q;

  always_ff @(posedge clk_i) begin
    s4_carry_q.hit  <= (s3_d2_q < SumW'(s3_r2_q)) &&
                       !(s3_same_q && (s3_rest2_q < SumW'(s3_r2_q)));
    s4_carry_q.d2nz <= |s3_d2_q;
    s4_carry_q.mid  <= s3_mid_q;
    s4_carry_q.mag  <= s3_mag_q;
    s4_carry_q.neg  <= s3_neg_q;
    s4_d2_q         <= s3_d2_q;
  end

  // square root, two radicand bits per stage
  logic             sq_valid_q [RootW];
  carry_t           sq_carry_q [RootW];
  logic [SumW-1:0]  sq_s_q     [RootW];
  logic [RemW-1:0]  sq_rem_q   [RootW];
  logic [RootW-1:0] sq_root_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic             v_in;
    carry_t           c_in;
    logic [SumW-1:0]  s_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  cur, trial;

    if (k == 0) begin : g_first
      assign v_in    = s4_valid_q;
      assign c_in    = s4_carry_q;
      assign s_in    = s4_d2_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_valid_q[k-1];
      assign c_in    = sq_carry_q[k-1];
      assign s_in    = sq_s_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
    end

    assign cur   = {rem_in, s_in[SumW-1-2*k -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[k] <= 1'b0;
      end else begin
        sq_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_carry_q[k] <= c_in;
      sq_s_q[k]     <= s_in;
      if (cur >= trial) begin
        sq_rem_q[k]  <= RemW'(cur - trial);
        sq_root_q[k] <= {root_in[RootW-2:0], 1'b1};
      end else begin
        sq_rem_q[k]  <= RemW'(cur);
        sq_root_q[k] <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end

  // normal divide: rounded |d| * 2^frac / len, one quotient bit per stage
  logic                 dv_valid_q [QW];
  carry_t               dv_carry_q [QW];
  logic [DivW-1:0]      dv_den_q   [QW];
  logic [2:0][DivW-1:0] dv_rem_q   [QW];
  logic [2:0][QW-1:0]   dv_quo_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic                 v_in;
    carry_t               c_in;
    logic [DivW-1:0]      den_in;
    logic [2:0][DivW-1:0] rem_in;
    logic [2:0][QW-1:0]   quo_in;
    logic [DivW-1:0]      shd;

    if (j == 0) begin : g_first
      logic [RootW-1:0] len;
      assign len    = sq_root_q[RootW-1];
      assign v_in   = sq_valid_q[RootW-1];
      assign c_in   = sq_carry_q[RootW-1];
      assign den_in = DivW'(len) << 1;
      for (genvar a = 0; a < 3; a++) begin : g_num
        assign rem_in[a] = (DivW'(c_in.mag[a]) << (NormFrac + 1)) + DivW'(len);
      end
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = dv_valid_q[j-1];
      assign c_in   = dv_carry_q[j-1];
      assign den_in = dv_den_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
    end

    assign shd = den_in << (QW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j] <= 1'b0;
      end else begin
        dv_valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_carry_q[j] <= c_in;
      dv_den_q[j]   <= den_in;
      for (int a = 0; a < 3; a++) begin
        if (rem_in[a] >= shd) begin
          dv_rem_q[j][a] <= rem_in[a] - shd;
          dv_quo_q[j][a] <= {quo_in[a][QW-2:0], 1'b1};
        end else begin
          dv_rem_q[j][a] <= rem_in[a];
          dv_quo_q[j][a] <= {quo_in[a][QW-2:0], 1'b0};
        end
      end
    end
  end

  // output stage: saturate, sign, clear fields of a miss and the normal of a zero-distance hit
  localparam logic [QW-1:0] One = QW'(1) << NormFrac;

  carry_t             fin;
  logic [2:0][QW-1:0] nq;
  logic [2:0][QW-1:0] nsig;
  out_t               result_d, result_q;
  logic               valid_q;

  assign fin = dv_carry_q[QW-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nq[a]   = (dv_quo_q[QW-1][a] > One) ? One : dv_quo_q[QW-1][a];
      nsig[a] = fin.neg[a] ? (~nq[a] + 1'b1) : nq[a];
      if (!(fin.hit && fin.d2nz)) begin
        nsig[a] = '0;
      end
    end
    result_d.in_contact = fin.hit;
    result_d.mid_x      = fin.hit ? fin.mid[0] : '0;
    result_d.mid_y      = fin.hit ? fin.mid[1] : '0;
    result_d.mid_z      = fin.hit ? fin.mid[2] : '0;
    result_d.normal_x   = nsig[0];
    result_d.normal_y   = nsig[1];
    result_d.normal_z   = nsig[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= start;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      valid_q    <= dv_valid_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy     = 1'b0;
  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* src/spct_checker.sv */
// port-level checks for the sphere pair contact test
// depends on spct_pkg; bound to sphere_pair_contact_test
module spct_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           valid_o,
  input spct_pkg::out_t result_o
);
  import spct_pkg::*;

  localparam logic signed [NormW-1:0] PosOne = NormW'(1) << NormFrac;
  localparam logic signed [NormW-1:0] NegOne = -PosOne;

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // every valid result must match an accepted item; the output is registered after the last divide stage
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, Latency + 1))
    else $error("result without an accepted item");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !result_o.in_contact) |->
      (result_o.mid_x == 0 && result_o.mid_y == 0 && result_o.mid_z == 0 &&
       result_o.normal_x == 0 && result_o.normal_y == 0 && result_o.normal_z == 0))
    else $error("miss with nonzero fields");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.normal_x <= PosOne && result_o.normal_x >= NegOne &&
                 result_o.normal_y <= PosOne && result_o.normal_y >= NegOne &&
                 result_o.normal_z <= PosOne && result_o.normal_z >= NegOne))
    else $error("normal component out of range");

endmodule

bind sphere_pair_contact_test spct_checker u_spct_checker (.*);
